// ===== hdl/ged_pkg.sv =====
// ged_pkg: shared types, register indexes, event codes and reset values
// for the gesture event detector; no dependencies
package ged_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned FlexW = 12;
  localparam int unsigned AngleW = 16;
  localparam int unsigned CenterW = 15;
  localparam int unsigned GapW = 16;
  localparam int unsigned EventW = 3;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIndexW-1:0] REG_FLEX_ONE_THRESH = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_FLEX_TWO_THRESH = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_RIGHT_EDGE = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_LEFT_EDGE = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_CENTER_BAND = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_PLAY_PAUSE_GAP = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_VOLUME_GAP = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_TRACK_GAP = 3'd7;

  localparam logic [EventW-1:0] EV_NONE = 3'd0;
  localparam logic [EventW-1:0] EV_PLAY = 3'd1;
  localparam logic [EventW-1:0] EV_VOL_UP = 3'd2;
  localparam logic [EventW-1:0] EV_VOL_DOWN = 3'd3;
  localparam logic [EventW-1:0] EV_NEXT = 3'd4;
  localparam logic [EventW-1:0] EV_PREV = 3'd5;

  typedef enum logic [1:0] {
    ZONE_CENTER = 2'd0,
    ZONE_RIGHT  = 2'd1,
    ZONE_LEFT   = 2'd2
  } zone_t;

  typedef struct packed {
    logic [FlexW-1:0]          flex_one_thresh;
    logic [FlexW-1:0]          flex_two_thresh;
    logic signed [AngleW-1:0]  right_edge;
    logic signed [AngleW-1:0]  left_edge;
    logic [CenterW-1:0]        center_band;
    logic [GapW-1:0]           play_pause_gap_ms;
    logic [GapW-1:0]           volume_gap_ms;
    logic [GapW-1:0]           track_gap_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    flex_one_thresh:   12'd2048,
    flex_two_thresh:   12'd2048,
    right_edge:        16'sd2500,
    left_edge:         -16'sd2500,
    center_band:       15'd1000,
    play_pause_gap_ms: 16'd600,
    volume_gap_ms:     16'd300,
    track_gap_ms:      16'd800
  };

  typedef struct packed {
    logic [TimeW-1:0]          now_ms;
    logic [FlexW-1:0]          flex_one;
    logic [FlexW-1:0]          flex_two;
    logic signed [AngleW-1:0]  tilt_angle;
  } sample_t;

endpackage

// ===== hdl/ged_if.sv =====
// ged_if: valid/ready channel interfaces for samples and events
// depends on ged_pkg
interface ged_sample_if import ged_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TimeW-1:0]          now_ms;
  logic [FlexW-1:0]          flex_one;
  logic [FlexW-1:0]          flex_two;
  logic signed [AngleW-1:0]  tilt_angle;

  modport source(output valid, now_ms, flex_one, flex_two, tilt_angle, input ready);
  modport sink(input valid, now_ms, flex_one, flex_two, tilt_angle, output ready);
endinterface

interface ged_event_if import ged_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_code;

  modport source(output valid, event_code, input ready);
  modport sink(input valid, event_code, output ready);
endinterface

// ===== hdl/ged_cfg_regs.sv =====
// ged_cfg_regs: configuration register bank with indexed write port
// depends on ged_pkg
module ged_cfg_regs import ged_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLEX_ONE_THRESH: cfg.flex_one_thresh <= cfg_wdata[FlexW-1:0];
        REG_FLEX_TWO_THRESH: cfg.flex_two_thresh <= cfg_wdata[FlexW-1:0];
        REG_RIGHT_EDGE:      cfg.right_edge <= cfg_wdata;
        REG_LEFT_EDGE:       cfg.left_edge <= cfg_wdata;
        REG_CENTER_BAND:     cfg.center_band <= cfg_wdata[CenterW-1:0];
        REG_PLAY_PAUSE_GAP:  cfg.play_pause_gap_ms <= cfg_wdata;
        REG_VOLUME_GAP:      cfg.volume_gap_ms <= cfg_wdata;
        REG_TRACK_GAP:       cfg.track_gap_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/ged_event_core.sv =====
// ged_event_core: per-sample event decision, cooldown timestamps and tilt zone
// depends on ged_pkg
module ged_event_core import ged_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  sample_t           sample,
  input  logic              fire,
  output logic [EventW-1:0] event_code
);

  zone_t            tilt_zone, tilt_zone_next;
  logic [TimeW-1:0] last_play_time, last_vol_up_time, last_vol_down_time, last_track_time;
  logic             upd_play, upd_vol_up, upd_vol_down, upd_track;

  logic                     bent1, bent2;
  logic                     play_ok, vol_up_ok, vol_down_ok, track_ok;
  logic signed [AngleW-1:0] angle;
  logic [AngleW:0]          angle_wide, magnitude;
  logic [TimeW-1:0]         now;

  assign now = sample.now_ms;
  assign angle = $signed(sample.tilt_angle);
  assign angle_wide = {angle[AngleW-1], angle};
  assign magnitude = angle[AngleW-1] ? (~angle_wide + 1'b1) : angle_wide;

  assign bent1 = sample.flex_one >= cfg.flex_one_thresh;
  assign bent2 = sample.flex_two >= cfg.flex_two_thresh;

  // wrapping time differences against the cooldowns
  assign play_ok = (now - last_play_time) >= {{(TimeW-GapW){1'b0}}, cfg.play_pause_gap_ms};
  assign vol_up_ok = (now - last_vol_up_time) >= {{(TimeW-GapW){1'b0}}, cfg.volume_gap_ms};
  assign vol_down_ok = (now - last_vol_down_time) >= {{(TimeW-GapW){1'b0}}, cfg.volume_gap_ms};
  assign track_ok = (now - last_track_time) >= {{(TimeW-GapW){1'b0}}, cfg.track_gap_ms};

  always_comb begin
    event_code = EV_NONE;
    tilt_zone_next = tilt_zone;
    upd_play = 1'b0;
    upd_vol_up = 1'b0;
    upd_vol_down = 1'b0;
    upd_track = 1'b0;
    if (bent1 && bent2 && play_ok) begin
      event_code = EV_PLAY;
      upd_play = 1'b1;
    end else if (bent2 && vol_up_ok) begin
      event_code = EV_VOL_UP;
      upd_vol_up = 1'b1;
    end else if (bent1 && vol_down_ok) begin
      event_code = EV_VOL_DOWN;
      upd_vol_down = 1'b1;
    end else if (angle > cfg.right_edge) begin
      tilt_zone_next = ZONE_RIGHT;
      if (tilt_zone != ZONE_RIGHT && track_ok) begin
        event_code = EV_NEXT;
        upd_track = 1'b1;
      end
    end else if (angle < cfg.left_edge) begin
      tilt_zone_next = ZONE_LEFT;
      if (tilt_zone != ZONE_LEFT && track_ok) begin
        event_code = EV_PREV;
        upd_track = 1'b1;
      end
    end else if (magnitude < {2'b00, cfg.center_band}) begin
      tilt_zone_next = ZONE_CENTER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_zone <= ZONE_CENTER;
      last_play_time <= '0;
      last_vol_up_time <= '0;
      last_vol_down_time <= '0;
      last_track_time <= '0;
    end else if (fire) begin
      tilt_zone <= tilt_zone_next;
      if (upd_play) last_play_time <= now;
      if (upd_vol_up) last_vol_up_time <= now;
      if (upd_vol_down) last_vol_down_time <= now;
      if (upd_track) last_track_time <= now;
    end
  end

  a_play_stamp: assert property (@(posedge clk) disable iff (rst)
    fire && event_code == EV_PLAY |=> last_play_time == $past(now))
    else $error("play timestamp not taken");

  a_next_zone: assert property (@(posedge clk) disable iff (rst)
    fire && event_code == EV_NEXT |=> tilt_zone == ZONE_RIGHT)
    else $error("next track without right zone");

  a_zone_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(tilt_zone) && $stable(last_track_time))
    else $error("state changed without a sample");

endmodule

// ===== hdl/gesture_event_detector.sv =====
// gesture_event_detector: top level, input register, decision core, result register
// depends on ged_pkg, ged_if, ged_cfg_regs, ged_event_core
//
// samples (sink): one transfer per sensor sample (now_ms, flex_one, flex_two,
//   tilt_angle). events (source): exactly one event_code per sample, in order.
// cfg_we / cfg_index / cfg_wdata: register write, taken at any edge with
//   cfg_we high; write only while no sample is in flight.
// path: an accepted sample passes through the input register, then decision
//   logic into the result register.
// throughput: one sample per cycle while the event side is ready; the compares
//   and the four 32-bit cooldown subtractions fit between the two registers.
// reset: registers return to their reset values, tilt zone to center, all
//   cooldown timestamps to zero, both stages empty.
// stall: while events.ready is low the result holds; the input register, if
//   empty, still takes one more sample, then samples.ready drops until the result
//   is taken.
module gesture_event_detector import ged_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  ged_sample_if.sink           samples,
  ged_event_if.source          events
);

  cfg_t              cfg;
  sample_t           s1_data;
  logic              s1_valid;
  logic              out_valid;
  logic [EventW-1:0] out_code;
  logic [EventW-1:0] core_code;
  logic              out_free;
  logic              fire;

  ged_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ged_event_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sample     (s1_data),
    .fire       (fire),
    .event_code (core_code)
  );

  assign out_free = !out_valid || events.ready;
  assign fire = s1_valid && out_free;
  assign samples.ready = !s1_valid || out_free;
  assign events.valid = out_valid;
  assign events.event_code = out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (samples.ready) s1_valid <= samples.valid;
      if (out_free) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_data.now_ms <= samples.now_ms;
      s1_data.flex_one <= samples.flex_one;
      s1_data.flex_two <= samples.flex_two;
      s1_data.tilt_angle <= samples.tilt_angle;
    end
    if (fire) out_code <= core_code;
  end

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_code <= EV_PREV))
    else $error("event code out of range");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid && out_code == $past(core_code))
    else $error("result register not loaded");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_data))
    else $error("held sample lost");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for gesture_event_detector, random and directed samples
// with an event predictor and in-order event check; depends on ged_pkg, ged_if and the rtl
module tb_top;
  import ged_pkg::*;

  localparam int ClkHalf = 10;
  localparam int TimeoutCycles = 2_000_000;
  localparam int PhaseItems = 285;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_wdata;

  ged_sample_if samples_ch ();
  ged_event_if  events_ch ();

  gesture_event_detector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .samples   (samples_ch.sink),
    .events    (events_ch.source)
  );

  cfg_t              shadow = CFG_RESET;
  zone_t             hand_zone = ZONE_CENTER;
  logic [TimeW-1:0]  play_stamp = '0;
  logic [TimeW-1:0]  vol_up_stamp = '0;
  logic [TimeW-1:0]  vol_down_stamp = '0;
  logic [TimeW-1:0]  track_stamp = '0;
  logic [EventW-1:0] expected_events[$];
  logic [TimeW-1:0]  clock_ms = '0;
  int                fail_count = 0;
  bit                tx_gaps_on = 1'b1;
  bit                rx_stalls_on = 1'b1;
  int                long_hold_req = 0;
  int                rx_stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  initial begin
    repeat (TimeoutCycles) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [EventW-1:0] predict_event(input sample_t s);
    logic [TimeW-1:0]  since_play, since_vol_up, since_vol_down, since_track;
    logic              bent1, bent2;
    logic [EventW-1:0] code;
    int                angle, mag;
    code = EV_NONE;
    bent1 = s.flex_one >= shadow.flex_one_thresh;
    bent2 = s.flex_two >= shadow.flex_two_thresh;
    since_play = s.now_ms - play_stamp;
    since_vol_up = s.now_ms - vol_up_stamp;
    since_vol_down = s.now_ms - vol_down_stamp;
    since_track = s.now_ms - track_stamp;
    angle = int'($signed(s.tilt_angle));
    mag = (angle < 0) ? -angle : angle;
    if (bent1 && bent2 && since_play >= TimeW'(shadow.play_pause_gap_ms)) begin
      code = EV_PLAY;
      play_stamp = s.now_ms;
    end else if (bent2 && since_vol_up >= TimeW'(shadow.volume_gap_ms)) begin
      code = EV_VOL_UP;
      vol_up_stamp = s.now_ms;
    end else if (bent1 && since_vol_down >= TimeW'(shadow.volume_gap_ms)) begin
      code = EV_VOL_DOWN;
      vol_down_stamp = s.now_ms;
    end else if (angle > int'($signed(shadow.right_edge))) begin
      if (hand_zone != ZONE_RIGHT && since_track >= TimeW'(shadow.track_gap_ms)) begin
        code = EV_NEXT;
        track_stamp = s.now_ms;
      end
      hand_zone = ZONE_RIGHT;
    end else if (angle < int'($signed(shadow.left_edge))) begin
      if (hand_zone != ZONE_LEFT && since_track >= TimeW'(shadow.track_gap_ms)) begin
        code = EV_PREV;
        track_stamp = s.now_ms;
      end
      hand_zone = ZONE_LEFT;
    end else if (mag < int'(shadow.center_band)) begin
      hand_zone = ZONE_CENTER;
    end
    return code;
  endfunction

  // predict on every accepted sample, then check every accepted event
  always @(posedge clk) begin
    sample_t           taken;
    logic [EventW-1:0] want;
    if (!rst) begin
      if (samples_ch.valid && samples_ch.ready) begin
        taken.now_ms = samples_ch.now_ms;
        taken.flex_one = samples_ch.flex_one;
        taken.flex_two = samples_ch.flex_two;
        taken.tilt_angle = samples_ch.tilt_angle;
        expected_events.push_back(predict_event(taken));
      end
      if (events_ch.valid && events_ch.ready) begin
        if (expected_events.size() == 0) begin
          $error("event_code: expected none, actual %0d", events_ch.event_code);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (events_ch.event_code !== want) begin
            $error("event_code: expected %0d, actual %0d", want, events_ch.event_code);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // event sink with random stalls and long hold-offs on request
  always @(negedge clk) begin
    if (long_hold_req > 0) begin
      rx_stall_left = long_hold_req;
      long_hold_req = 0;
    end else if (rx_stall_left == 0 && rx_stalls_on && $urandom_range(0, 99) < 20) begin
      rx_stall_left = idle_length();
    end
    if (rx_stall_left > 0) begin
      events_ch.ready <= 1'b0;
      rx_stall_left--;
    end else begin
      events_ch.ready <= 1'b1;
    end
  end

  task automatic send_sample(input sample_t s);
    int gap;
    samples_ch.valid <= 1'b1;
    samples_ch.now_ms <= s.now_ms;
    samples_ch.flex_one <= s.flex_one;
    samples_ch.flex_two <= s.flex_two;
    samples_ch.tilt_angle <= s.tilt_angle;
    do @(posedge clk); while (!samples_ch.ready);
    @(negedge clk);
    gap = (tx_gaps_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_fields(input logic [TimeW-1:0] now, input int f1, input int f2,
                             input int ang);
    sample_t s;
    s.now_ms = now;
    s.flex_one = FlexW'(f1);
    s.flex_two = FlexW'(f2);
    s.tilt_angle = AngleW'(ang);
    send_sample(s);
  endtask

  task automatic wait_events_drained();
    samples_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_FLEX_ONE_THRESH: shadow.flex_one_thresh = data[FlexW-1:0];
      REG_FLEX_TWO_THRESH: shadow.flex_two_thresh = data[FlexW-1:0];
      REG_RIGHT_EDGE:      shadow.right_edge = data[AngleW-1:0];
      REG_LEFT_EDGE:       shadow.left_edge = data[AngleW-1:0];
      REG_CENTER_BAND:     shadow.center_band = data[CenterW-1:0];
      REG_PLAY_PAUSE_GAP:  shadow.play_pause_gap_ms = data[GapW-1:0];
      REG_VOLUME_GAP:      shadow.volume_gap_ms = data[GapW-1:0];
      REG_TRACK_GAP:       shadow.track_gap_ms = data[GapW-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    write_reg(REG_FLEX_ONE_THRESH, CfgDataW'(c.flex_one_thresh));
    write_reg(REG_FLEX_TWO_THRESH, CfgDataW'(c.flex_two_thresh));
    write_reg(REG_RIGHT_EDGE, c.right_edge);
    write_reg(REG_LEFT_EDGE, c.left_edge);
    write_reg(REG_CENTER_BAND, CfgDataW'(c.center_band));
    write_reg(REG_PLAY_PAUSE_GAP, c.play_pause_gap_ms);
    write_reg(REG_VOLUME_GAP, c.volume_gap_ms);
    write_reg(REG_TRACK_GAP, c.track_gap_ms);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [FlexW-1:0] flex_reading(input logic [FlexW-1:0] trig);
    case ($urandom_range(0, 9))
      0:       return trig;
      1:       return trig - 1'b1;
      2, 3:    return FlexW'($urandom_range(trig, 4095));
      4:       return FlexW'($urandom_range(0, 4095));
      default: return (trig == 0) ? '0 : FlexW'($urandom_range(0, trig - 1));
    endcase
  endfunction

  function automatic logic [AngleW-1:0] tilt_reading();
    int right_on, left_on, center, angle;
    right_on = int'($signed(shadow.right_edge));
    left_on = int'($signed(shadow.left_edge));
    center = int'(shadow.center_band);
    case ($urandom_range(0, 11))
      0, 1, 2: angle = right_on + int'($urandom_range(1, 4000));
      3, 4, 5: angle = left_on - int'($urandom_range(1, 4000));
      6, 7: begin
        angle = int'($urandom_range(0, center));
        if ($urandom_range(0, 1)) angle = -angle;
      end
      8: begin
        angle = center + int'($urandom_range(0, 2000));
        if ($urandom_range(0, 1)) angle = -angle;
      end
      9: begin
        case ($urandom_range(0, 5))
          0:       angle = right_on;
          1:       angle = left_on;
          2:       angle = center;
          3:       angle = -center;
          4:       angle = right_on + 1;
          default: angle = left_on - 1;
        endcase
      end
      10: angle = int'($signed(AngleW'($urandom())));
      default: begin
        case ($urandom_range(0, 3))
          0:       angle = -32768;
          1:       angle = 32767;
          2:       angle = -18000;
          default: angle = 18000;
        endcase
      end
    endcase
    if (angle > 32767) angle = 32767;
    if (angle < -32768) angle = -32768;
    return AngleW'(angle);
  endfunction

  function automatic sample_t next_sample();
    sample_t s;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) clock_ms = clock_ms + TimeW'($urandom_range(0, 250));
    else if (pick < 93) clock_ms = clock_ms + TimeW'($urandom_range(250, 70000));
    else if (pick < 97) clock_ms = $urandom();
    else clock_ms = 32'hFFFF_FFFF - TimeW'($urandom_range(0, 2000));
    s.now_ms = clock_ms;
    s.flex_one = flex_reading(shadow.flex_one_thresh);
    s.flex_two = flex_reading(shadow.flex_two_thresh);
    s.tilt_angle = tilt_reading();
    return s;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.flex_one_thresh = FlexW'($urandom_range(1024, 3500));
    c.flex_two_thresh = FlexW'($urandom_range(1024, 3500));
    c.right_edge = AngleW'(int'($urandom_range(0, 8000)) - 2000);
    c.left_edge = AngleW'(2000 - int'($urandom_range(0, 8000)));
    c.center_band = CenterW'($urandom_range(0, 4000));
    c.play_pause_gap_ms = GapW'($urandom_range(0, 1200));
    c.volume_gap_ms = GapW'($urandom_range(0, 1200));
    c.track_gap_ms = GapW'($urandom_range(0, 1200));
    return c;
  endfunction

  // play, then volumes as each higher one cools down, all blocked, one-sensor, time wrap
  task automatic test_flex_priority();
    send_fields(32'd1000, 4095, 4095, 0);
    send_fields(32'd1100, 4095, 4095, 0);
    send_fields(32'd1200, 4095, 4095, 0);
    send_fields(32'd1300, 4095, 4095, 0);
    send_fields(32'd1300, 2047, 2047, 0);
    send_fields(32'd1600, 2048, 0, 0);
    send_fields(32'hFFFF_FFF0, 2048, 2048, 0);
    send_fields(32'h0000_0100, 4095, 4095, 0);
  endtask

  // zone entry, holding, hysteresis band, blocked track change, extreme angles
  task automatic test_tilt_zones();
    send_fields(32'd2000, 0, 0, 2501);
    send_fields(32'd2100, 0, 0, 18000);
    send_fields(32'd2200, 0, 0, 2000);
    send_fields(32'd2300, 0, 0, 2501);
    send_fields(32'd2400, 0, 0, 999);
    send_fields(32'd2500, 0, 0, -2501);
    send_fields(32'd3500, 0, 0, -32768);
    send_fields(32'd3600, 0, 0, 0);
    send_fields(32'd3700, 0, 0, -32768);
    send_fields(32'd3800, 0, 0, 1000);
    send_fields(32'd3900, 0, 0, 32767);
    send_fields(32'd4800, 0, 0, -2500);
    send_fields(32'd5000, 4095, 0, -5000);
    send_fields(32'd5100, 0, 0, -5000);
  endtask

  // right and left zones overlapping: right wins
  task automatic test_threshold_order();
    cfg_t c;
    wait_events_drained();
    c = shadow;
    c.right_edge = -16'sd1000;
    c.left_edge = 16'sd1000;
    c.center_band = '0;
    write_config(c);
    send_fields(32'd10000, 0, 0, 0);
    send_fields(32'd20000, 0, 0, 500);
  endtask

  task automatic test_random_phases();
    cfg_t c;
    for (int phase = 0; phase < 6; phase++) begin
      wait_events_drained();
      case (phase)
        0: c = CFG_RESET;
        1: c = '{flex_one_thresh: 12'd4095, flex_two_thresh: 12'd4095,
                 right_edge: 16'sd18000, left_edge: -16'sd18000,
                 center_band: 15'd18000, play_pause_gap_ms: 16'd0,
                 volume_gap_ms: 16'd0, track_gap_ms: 16'd0};
        2: c = '{flex_one_thresh: 12'd0, flex_two_thresh: 12'd0,
                 right_edge: -16'sd18000, left_edge: 16'sd18000,
                 center_band: 15'd0, play_pause_gap_ms: 16'd65535,
                 volume_gap_ms: 16'd65535, track_gap_ms: 16'd65535};
        default: c = random_config();
      endcase
      write_config(c);
      tx_gaps_on = (phase != 4);
      rx_stalls_on = (phase != 4);
      repeat (PhaseItems) send_sample(next_sample());
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // sink holds off while samples keep coming, so the input side backs up
  task automatic test_stall_fill();
    wait_events_drained();
    tx_gaps_on = 1'b0;
    long_hold_req = 80;
    repeat (30) send_sample(next_sample());
    tx_gaps_on = 1'b1;
    wait_events_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_FLEX_ONE_THRESH;
    cfg_wdata = '0;
    samples_ch.valid = 1'b0;
    samples_ch.now_ms = '0;
    samples_ch.flex_one = '0;
    samples_ch.flex_two = '0;
    samples_ch.tilt_angle = '0;
    events_ch.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_flex_priority();
    test_tilt_zones();
    test_threshold_order();
    test_random_phases();
    test_stall_fill();

    wait_events_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ged_pkg.sv
hdl/ged_if.sv
hdl/ged_cfg_regs.sv
hdl/ged_event_core.sv
hdl/gesture_event_detector.sv
bench/tb_top.sv
